[hdl/vmm_pkg.sv]
// Shared types and constants for the vector-matrix multiply block.
// No dependencies; compiled first.
`default_nettype none

package vmm_pkg;

  // Default storage sizes
  localparam int unsigned MaxRowsDef = 16;
  localparam int unsigned MaxColsDef = 16;

  // Fixed field widths
  localparam int unsigned RegW    = 5;
  localparam int unsigned ValW    = 32;
  localparam int unsigned ColIdxW = 4;
  localparam int unsigned CfgIdxW = 1;

  // Register indexes
  typedef enum logic [CfgIdxW-1:0] {
    CfgRows = 1'b0,
    CfgCols = 1'b1
  } cfg_idx_e;

  localparam logic [RegW-1:0] RowsReset = 5'd16;
  localparam logic [RegW-1:0] ColsReset = 5'd16;

  // Item commands
  typedef enum logic {
    CmdLoad   = 1'b0,
    CmdVector = 1'b1
  } cmd_e;

  typedef struct packed {
    logic                   cmd;
    logic signed [ValW-1:0] operand_value;
  } in_item_t;

  typedef struct packed {
    logic signed [ValW-1:0] sum_value;
    logic [ColIdxW-1:0]     column_index;
    logic                   last_flag;
  } out_item_t;

  // Sequencer states
  typedef enum logic [2:0] {
    StIdle,
    StMac,
    StDrain,
    StEmitRd,
    StEmitLd
  } state_e;

  // Column-sum bank strobes
  typedef struct packed {
    logic rd_en;
    logic wr_en;
  } sb_ctrl_t;

endpackage

`default_nettype wire

[hdl/vmm_stream_if.sv]
// Valid/ready stream channel carrying one item per handshake.
// Payload type is a parameter; no package dependency.
`default_nettype none

interface vmm_stream_if #(
  parameter type item_t = logic
) ();
  logic  valid;
  logic  ready;
  item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

[hdl/vmm_sum_bank.sv]
// Column accumulator memory with per-entry valid bits and registered read.
// Depends on vmm_pkg.
`default_nettype none

module vmm_sum_bank #(
  parameter int unsigned MAX_COLS = vmm_pkg::MaxColsDef,
  localparam int unsigned ColW = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1
) (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire vmm_pkg::sb_ctrl_t        ctrl_i,
  input  wire logic [ColW-1:0]          rd_addr_i,
  input  wire logic [ColW-1:0]          wr_addr_i,
  input  wire logic [vmm_pkg::ValW-1:0] wr_data_i,
  output logic      [vmm_pkg::ValW-1:0] rd_data_o
);
  import vmm_pkg::*;

  logic [ValW-1:0] mem [MAX_COLS];
  logic [MAX_COLS-1:0] valid_q;
  logic [ValW-1:0] rd_data_q;
  logic            rd_valid_q;

  // Valid bits: an entry never written reads as zero
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q    <= '0;
      rd_valid_q <= 1'b0;
    end else begin
      if (ctrl_i.wr_en) begin
        valid_q[wr_addr_i] <= 1'b1;
      end
      if (ctrl_i.rd_en) begin
        rd_valid_q <= valid_q[rd_addr_i];
      end
    end
  end

  // Storage, one write and one read port
  always_ff @(posedge clk_i) begin
    if (ctrl_i.wr_en) begin
      mem[wr_addr_i] <= wr_data_i;
    end
    if (ctrl_i.rd_en) begin
      rd_data_q <= mem[rd_addr_i];
    end
  end

  assign rd_data_o = rd_valid_q ? rd_data_q : '0;

endmodule

`default_nettype wire

[hdl/vector_matrix_multiply_top.sv]
// Top level of the vector-matrix multiply block: sequencer, matrix store, shared MAC.
// Depends on vmm_pkg, vmm_stream_if and vmm_sum_bank.
//
// Row vector times stored matrix on wrapping 32-bit integers. A load item (cmd 0)
// writes the next matrix entry row-major; the block is ready again the next cycle.
// A vector item (cmd 1) runs one shared multiply-accumulate over every column
// in use, one column per cycle through a three-stage path (matrix read, multiply,
// accumulate), and keeps the input stalled until that pass has drained. After the
// element for the last row, the accumulators are read out one result per column,
// each through a read state and a load state, the read waiting while the output
// is stalled; the last result sits in the output register while new items are
// taken. The matrix store has no reset: vector items must only touch loaded entries.
`default_nettype none

module vector_matrix_multiply_top #(
  parameter int unsigned MAX_ROWS = vmm_pkg::MaxRowsDef,
  parameter int unsigned MAX_COLS = vmm_pkg::MaxColsDef
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        cfg_we_i,
  input  wire logic [vmm_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  wire logic [vmm_pkg::RegW-1:0]    cfg_data_i,
  vmm_stream_if.sink                       in_if,
  vmm_stream_if.source                     out_if
);
  import vmm_pkg::*;

  localparam int unsigned Depth = MAX_ROWS * MAX_COLS;
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned TotW  = $clog2(Depth + 1);
  localparam int unsigned RowW  = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int unsigned ColW  = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
  localparam int unsigned RowNW = $clog2(MAX_ROWS + 1);
  localparam int unsigned ColNW = $clog2(MAX_COLS + 1);

  state_e state_q, state_d;

  logic [RegW-1:0]  rows_q, cols_q;
  logic [RowNW-1:0] rows_eff;
  logic [ColNW-1:0] cols_eff;
  logic [TotW-1:0]  total;

  logic [AddrW-1:0] lpos_q, lpos_d, lpos_eff;
  logic [TotW-1:0]  lpos_inc;
  logic [RowW-1:0]  vpos_q, vpos_d, vpos_eff;
  logic [RowNW-1:0] vpos_inc;
  logic             final_elem;

  logic [ValW-1:0]  opnd_q;
  logic [AddrW-1:0] base_q;
  logic             first_q, final_q;
  logic [ColW-1:0]  cnt_q, cnt_d;
  logic             cnt_last;

  logic [ValW-1:0]  mat_mem [Depth];
  logic [ValW-1:0]  mat_rd_q;
  logic             p1_q, p2_q;
  logic [ColW-1:0]  c1_q, c2_q;
  logic [ValW-1:0]  prod_q;

  sb_ctrl_t         sb_ctrl;
  logic [ColW-1:0]  sb_rd_addr;
  logic [ValW-1:0]  sb_rd_data, sb_wr_data;

  logic             in_acc, load_acc, vec_acc;
  logic             issue, out_free, out_load;
  logic             out_valid_q;
  out_item_t        out_item_q;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rows_q <= RowsReset;
      cols_q <= ColsReset;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CfgRows: rows_q <= cfg_data_i;
        CfgCols: cols_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Clamp counts to 1..max
  always_comb begin
    if (rows_q == '0) begin
      rows_eff = RowNW'(1);
    end else if (int'(rows_q) > int'(MAX_ROWS)) begin
      rows_eff = RowNW'(MAX_ROWS);
    end else begin
      rows_eff = RowNW'(rows_q);
    end
    if (cols_q == '0) begin
      cols_eff = ColNW'(1);
    end else if (int'(cols_q) > int'(MAX_COLS)) begin
      cols_eff = ColNW'(MAX_COLS);
    end else begin
      cols_eff = ColNW'(cols_q);
    end
  end

  assign total = TotW'(rows_eff) * TotW'(cols_eff);

  // Input handshake
  assign in_acc   = in_if.valid && in_if.ready;
  assign load_acc = in_acc && (in_if.data.cmd == CmdLoad);
  assign vec_acc  = in_acc && (in_if.data.cmd == CmdVector);

  // Load position with wrap
  always_comb begin
    lpos_eff = (TotW'(lpos_q) >= total) ? '0 : lpos_q;
    lpos_inc = TotW'(lpos_eff) + TotW'(1);
    lpos_d   = (lpos_inc >= total) ? '0 : AddrW'(lpos_inc);
  end

  // Vector position with wrap
  always_comb begin
    vpos_eff   = (RowNW'(vpos_q) >= rows_eff) ? '0 : vpos_q;
    vpos_inc   = RowNW'(vpos_eff) + RowNW'(1);
    final_elem = (vpos_inc >= rows_eff);
    vpos_d     = final_elem ? '0 : RowW'(vpos_inc);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lpos_q <= '0;
      vpos_q <= '0;
    end else begin
      if (load_acc) begin
        lpos_q <= lpos_d;
      end
      if (vec_acc) begin
        vpos_q <= vpos_d;
      end
    end
  end

  // Per-element operands
  always_ff @(posedge clk_i) begin
    if (vec_acc) begin
      opnd_q  <= in_if.data.operand_value;
      first_q <= (vpos_eff == '0);
      final_q <= final_elem;
      base_q  <= AddrW'(TotW'(vpos_eff) * TotW'(cols_eff));
    end
  end

  // Matrix store
  always_ff @(posedge clk_i) begin
    if (load_acc) begin
      mat_mem[lpos_eff] <= in_if.data.operand_value;
    end
    if (issue) begin
      mat_rd_q <= mat_mem[AddrW'(base_q + AddrW'(cnt_q))];
    end
  end

  assign cnt_last = (ColNW'(cnt_q) == (cols_eff - ColNW'(1)));
  assign out_free = !out_valid_q || out_if.ready;

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      StIdle:   if (vec_acc) state_d = StMac;
      StMac:    if (cnt_last) state_d = StDrain;
      StDrain:  if (!p1_q && !p2_q) state_d = final_q ? StEmitRd : StIdle;
      StEmitRd: if (out_free) state_d = StEmitLd;
      StEmitLd: state_d = cnt_last ? StIdle : StEmitRd;
      default:  state_d = StIdle;
    endcase
  end

  // Sequencer outputs
  always_comb begin
    in_if.ready   = 1'b0;
    issue         = 1'b0;
    out_load      = 1'b0;
    sb_ctrl.rd_en = p1_q;
    sb_ctrl.wr_en = p2_q;
    sb_rd_addr    = c1_q;
    cnt_d         = cnt_q;
    unique case (state_q)
      StIdle: begin
        in_if.ready = 1'b1;
        if (vec_acc) cnt_d = '0;
      end
      StMac: begin
        issue = 1'b1;
        if (!cnt_last) cnt_d = cnt_q + ColW'(1);
      end
      StDrain: begin
        cnt_d = '0;
      end
      StEmitRd: begin
        sb_ctrl.rd_en = out_free;
        sb_rd_addr    = cnt_q;
      end
      StEmitLd: begin
        out_load = 1'b1;
        if (!cnt_last) cnt_d = cnt_q + ColW'(1);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      cnt_q   <= '0;
      p1_q    <= 1'b0;
      p2_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      p1_q    <= issue;
      p2_q    <= p1_q;
    end
  end

  // MAC path: column tag follows the data, product is registered
  always_ff @(posedge clk_i) begin
    c1_q   <= cnt_q;
    c2_q   <= c1_q;
    prod_q <= opnd_q * mat_rd_q;
  end

  assign sb_wr_data = first_q ? prod_q : (sb_rd_data + prod_q);

  vmm_sum_bank #(
    .MAX_COLS (MAX_COLS)
  ) u_sum_bank (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .ctrl_i    (sb_ctrl),
    .rd_addr_i (sb_rd_addr),
    .wr_addr_i (c2_q),
    .wr_data_i (sb_wr_data),
    .rd_data_o (sb_rd_data)
  );

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_if.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_item_q.sum_value    <= sb_rd_data;
      out_item_q.column_index <= ColIdxW'(cnt_q);
      out_item_q.last_flag    <= cnt_last;
    end
  end

  assign out_if.valid = out_valid_q;
  assign out_if.data  = out_item_q;

endmodule

`default_nettype wire

[hdl/vmm_checker.sv]
// Port-level assertions for the vector-matrix multiply top level, bound in below.
// Depends on vmm_pkg and vector_matrix_multiply_top.
`default_nettype none

module vmm_checker (
  input wire logic                        clk_i,
  input wire logic                        rst_ni,
  input wire logic                        in_valid_i,
  input wire logic                        in_ready_i,
  input wire logic                        in_cmd_i,
  input wire logic                        out_valid_i,
  input wire logic                        out_ready_i,
  input wire logic [vmm_pkg::ValW-1:0]    out_sum_i,
  input wire logic [vmm_pkg::ColIdxW-1:0] out_col_i,
  input wire logic                        out_last_i
);
  import vmm_pkg::*;

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_sum_i)
      && $stable(out_col_i) && $stable(out_last_i))
    else $error("result changed while stalled");

  // A vector item blocks the input for its MAC pass
  a_vec_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i && (in_cmd_i == CmdVector) |=> !in_ready_i)
    else $error("input ready right after a vector item");

  // No item is taken while a result sequence is still being read out
  a_emit_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_last_i |-> !in_ready_i)
    else $error("input ready in the middle of a result sequence");

endmodule

bind vector_matrix_multiply_top vmm_checker u_vmm_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_if.valid),
  .in_ready_i  (in_if.ready),
  .in_cmd_i    (in_if.data.cmd),
  .out_valid_i (out_if.valid),
  .out_ready_i (out_if.ready),
  .out_sum_i   (out_if.data.sum_value),
  .out_col_i   (out_if.data.column_index),
  .out_last_i  (out_if.data.last_flag)
);

`default_nettype wire

[dv/tb_top.sv]
// Self-checking testbench for vector_matrix_multiply_top: random and directed load/vector
// items, a cycle-free predictor of the column sums, and random stalls on both streams.
// Depends on vmm_pkg, vmm_stream_if and the RTL top level.
`default_nettype none

module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import vmm_pkg::*;

  localparam int unsigned MaxRows     = MaxRowsDef;
  localparam int unsigned MaxCols     = MaxColsDef;
  // Idle cycles before a register write, for a vector item's MAC pass to finish.
  localparam int unsigned DrainCycles = 48;

  // Item waiting to be driven; hold makes the driver wait for all sums first.
  typedef struct packed {
    logic     hold;
    in_item_t item;
  } send_item_t;

  logic                clk;
  logic                rst_n;
  logic                cfg_we;
  cfg_idx_e            cfg_idx;
  logic [RegW-1:0]     cfg_data;

  vmm_stream_if #(.item_t(in_item_t))  in_ch ();
  vmm_stream_if #(.item_t(out_item_t)) out_ch ();

  vector_matrix_multiply_top #(
    .MAX_ROWS(MaxRows),
    .MAX_COLS(MaxCols)
  ) uut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data),
    .in_if      (in_ch),
    .out_if     (out_ch)
  );

  // Stimulus and expected sums
  send_item_t  pending_items[$];
  out_item_t   expected_sums[$];

  // Predictor state
  logic [31:0]     matrix_q [MaxRows*MaxCols];
  logic [31:0]     col_sums [MaxCols];
  int unsigned     load_pos;
  int unsigned     row_pos;
  logic [RegW-1:0] rows_cfg;
  logic [RegW-1:0] cols_cfg;

  // Handshake bookkeeping
  logic        item_taken;
  logic        result_taken;
  int unsigned src_gap;
  int unsigned sink_wait;
  bit          src_calm;
  bit          sink_calm;

  int unsigned items_in;
  int unsigned results_seen;
  int unsigned settings_run;
  int unsigned error_count;

  always #5 clk = ~clk;

  // Register value as the block uses it: zero reads as one, large values saturate.
  function automatic int unsigned fit_count(logic [RegW-1:0] v, int unsigned maxv);
    if (v == '0) return 1;
    if (v > maxv) return maxv;
    return v;
  endfunction

  // Advance the predictor by one accepted item; final row pushes one sum per column.
  function automatic void absorb_item(in_item_t it);
    int unsigned rows;
    int unsigned cols;
    int unsigned total;
    logic [31:0] prod;
    out_item_t   res;
    rows  = fit_count(rows_cfg, MaxRows);
    cols  = fit_count(cols_cfg, MaxCols);
    total = rows * cols;
    if (it.cmd == CmdLoad) begin
      if (load_pos >= total) load_pos = 0;
      matrix_q[load_pos] = it.operand_value;
      load_pos++;
      if (load_pos >= total) load_pos = 0;
    end else begin
      if (row_pos >= rows) row_pos = 0;
      for (int unsigned c = 0; c < cols; c++) begin
        prod = it.operand_value * matrix_q[row_pos * cols + c];
        col_sums[c] = (row_pos == 0) ? prod : col_sums[c] + prod;
      end
      row_pos++;
      if (row_pos >= rows) begin
        row_pos = 0;
        for (int unsigned c = 0; c < cols; c++) begin
          res.sum_value    = col_sums[c];
          res.column_index = 4'(c);
          res.last_flag    = (c + 1 == cols);
          expected_sums.push_back(res);
        end
      end
    end
  endfunction

  // Compare one emitted sum with the oldest expectation.
  function automatic void check_sum(out_item_t got);
    out_item_t want;
    if (expected_sums.size() == 0) begin
      $display("%0t: unexpected result sum=%h col=%0d last=%b", $time,
               got.sum_value, got.column_index, got.last_flag);
      error_count++;
      return;
    end
    want = expected_sums.pop_front();
    results_seen++;
    if (got.sum_value !== want.sum_value) begin
      $display("%0t: sum_value expected %h actual %h (col %0d)", $time,
               want.sum_value, got.sum_value, want.column_index);
      error_count++;
    end
    if (got.column_index !== want.column_index) begin
      $display("%0t: column_index expected %0d actual %0d", $time,
               want.column_index, got.column_index);
      error_count++;
    end
    if (got.last_flag !== want.last_flag) begin
      $display("%0t: last_flag expected %b actual %b (col %0d)", $time,
               want.last_flag, got.last_flag, want.column_index);
      error_count++;
    end
  endfunction

  function automatic int unsigned draw_wait(bit calm);
    return calm ? 0 : $urandom_range(0, 19);
  endfunction

  // Operand mix: mostly full-range, some small signed, some extremes.
  function automatic logic [31:0] pick_operand();
    int unsigned roll;
    roll = $urandom_range(0, 9);
    if (roll == 0) begin
      case ($urandom_range(0, 4))
        0:       return 32'h8000_0000;
        1:       return 32'h7FFF_FFFF;
        2:       return 32'hFFFF_FFFF;
        3:       return 32'h0000_0001;
        default: return 32'h0000_0000;
      endcase
    end
    if (roll < 3) return $urandom_range(0, 200) - 100;
    return $urandom();
  endfunction

  function automatic void queue_item(cmd_e cmd, logic [31:0] v, logic hold);
    send_item_t s;
    s.hold               = hold;
    s.item.cmd           = cmd;
    s.item.operand_value = v;
    pending_items.push_back(s);
  endfunction

  // Monitor: registers, accepted items and emitted sums, all at the rising edge
  always @(posedge clk) begin
    if (rst_n) begin
      if (cfg_we) begin
        if (cfg_idx == CfgRows) rows_cfg = cfg_data;
        else                    cols_cfg = cfg_data;
      end
      item_taken   <= in_ch.valid && in_ch.ready;
      result_taken <= out_ch.valid && out_ch.ready;
      if (out_ch.valid && out_ch.ready) check_sum(out_ch.data);
      if (in_ch.valid && in_ch.ready) begin
        absorb_item(in_ch.data);
        items_in++;
      end
    end
  end

  // Driver: one item at a time from the pending queue, random gap after each
  always @(negedge clk) begin
    int unsigned g;
    if (rst_n && (!in_ch.valid || item_taken)) begin
      if (item_taken && $urandom_range(0, 31) == 0) src_calm <= ~src_calm;
      g = item_taken ? draw_wait(src_calm) : src_gap;
      if (g != 0) begin
        in_ch.valid <= 1'b0;
        src_gap     <= g - 1;
      end else if (pending_items.size() != 0 &&
                   !(pending_items[0].hold && expected_sums.size() != 0)) begin
        in_ch.valid <= 1'b1;
        in_ch.data  <= pending_items[0].item;
        void'(pending_items.pop_front());
        src_gap     <= 0;
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // Result sink: random stall after each accepted sum
  always @(negedge clk) begin
    int unsigned w;
    if (rst_n) begin
      if (result_taken) begin
        if ($urandom_range(0, 31) == 0) sink_calm <= ~sink_calm;
        w = draw_wait(sink_calm);
        out_ch.ready <= (w == 0);
        sink_wait    <= (w == 0) ? 0 : w - 1;
      end else if (sink_wait != 0) begin
        out_ch.ready <= 1'b0;
        sink_wait    <= sink_wait - 1;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  // Block until every item is in and every sum is out, then let the MAC settle.
  task automatic wait_idle();
    while (pending_items.size() != 0 || in_ch.valid || expected_sums.size() != 0)
      @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
  endtask

  task automatic write_reg(cfg_idx_e idx, logic [RegW-1:0] val);
    @(negedge clk);
    cfg_we   = 1'b1;
    cfg_idx  = idx;
    cfg_data = val;
    @(negedge clk);
    cfg_we   = 1'b0;
  endtask

  // One register setting: fill the whole matrix, then random vectors and noise.
  task automatic run_phase(logic [RegW-1:0] r, logic [RegW-1:0] c, int unsigned budget);
    int unsigned rows;
    int unsigned total;
    int unsigned count;
    int unsigned vecs;
    int unsigned roll;
    int unsigned n;
    wait_idle();
    if ($urandom_range(0, 1)) begin
      write_reg(CfgRows, r);
      write_reg(CfgCols, c);
    end else begin
      write_reg(CfgCols, c);
      write_reg(CfgRows, r);
    end
    settings_run++;
    rows  = fit_count(r, MaxRows);
    total = rows * fit_count(c, MaxCols);
    for (int unsigned i = 0; i < total; i++) queue_item(CmdLoad, pick_operand(), 1'b0);
    count = 0;
    vecs  = 0;
    while (count < budget) begin
      roll = $urandom_range(0, 9);
      if (roll < 7) begin
        // well-formed vector; the third one waits for all sums to drain first
        for (int unsigned i = 0; i < rows; i++)
          queue_item(CmdVector, pick_operand(), vecs == 2 && i == 0);
        vecs++;
        count += rows;
      end else if (roll < 9) begin
        // overwrite a few matrix entries mid-stream
        n = $urandom_range(1, 4);
        for (int unsigned i = 0; i < n; i++) queue_item(CmdLoad, pick_operand(), 1'b0);
        count += n;
      end else begin
        // broken vector: a run of one to rows elements that can misalign what follows
        n = $urandom_range(1, rows);
        for (int unsigned i = 0; i < n; i++) queue_item(CmdVector, pick_operand(), 1'b0);
        count += n;
      end
    end
  endtask

  initial begin
    clk          = 1'b0;
    rst_n        = 1'b0;
    cfg_we       = 1'b0;
    cfg_idx      = CfgRows;
    cfg_data     = '0;
    in_ch.valid  = 1'b0;
    in_ch.data   = '0;
    out_ch.ready = 1'b0;
    item_taken   = 1'b0;
    result_taken = 1'b0;
    src_gap      = 0;
    sink_wait    = 0;
    src_calm     = 1'b0;
    sink_calm    = 1'b0;
    load_pos     = 0;
    row_pos      = 0;
    rows_cfg     = RowsReset;
    cols_cfg     = ColsReset;
    items_in     = 0;
    results_seen = 0;
    settings_run = 1;
    error_count  = 0;
    for (int i = 0; i < MaxCols; i++) col_sums[i] = '0;
    for (int i = 0; i < MaxRows * MaxCols; i++) matrix_q[i] = '0;
    repeat (4) @(negedge clk);
    rst_n = 1'b1;

    // Directed: 2x3 matrix of extremes, vectors of extremes
    write_reg(CfgRows, 5'd2);
    write_reg(CfgCols, 5'd3);
    queue_item(CmdLoad, 32'h8000_0000, 1'b0);
    queue_item(CmdLoad, 32'h7FFF_FFFF, 1'b0);
    queue_item(CmdLoad, 32'hFFFF_FFFF, 1'b0);
    queue_item(CmdLoad, 32'h0000_0000, 1'b0);
    queue_item(CmdLoad, 32'h0000_0001, 1'b0);
    queue_item(CmdLoad, 32'h5555_5555, 1'b0);
    queue_item(CmdVector, 32'h0000_0001, 1'b0);
    queue_item(CmdVector, 32'h0000_0001, 1'b0);
    queue_item(CmdVector, 32'h8000_0000, 1'b0);
    queue_item(CmdVector, 32'hFFFF_FFFF, 1'b0);
    queue_item(CmdVector, 32'h7FFF_FFFF, 1'b0);
    queue_item(CmdVector, 32'h7FFF_FFFF, 1'b0);
    queue_item(CmdVector, 32'hFFFF_FFFF, 1'b0);
    queue_item(CmdVector, 32'h0000_0000, 1'b0);
    // load past the end wraps to entry zero
    queue_item(CmdLoad, 32'hAAAA_AAAA, 1'b0);
    queue_item(CmdVector, 32'h0000_0002, 1'b1);
    queue_item(CmdVector, 32'hFFFF_FFFD, 1'b0);
    // lone element: leaves both counters past the range of the next setting
    queue_item(CmdVector, 32'h1234_5678, 1'b0);
    queue_item(CmdLoad, 32'hDEAD_BEEF, 1'b0);

    // Random phases over settings, extremes and out-of-range values included
    run_phase(5'd1, 5'd1, 20);
    run_phase(5'd4, 5'd3, 20);
    run_phase(5'd0, 5'd31, 20);
    run_phase(5'd31, 5'd0, 20);
    run_phase(5'($urandom_range(2, 8)), 5'($urandom_range(2, 8)), 20);
    run_phase(5'($urandom_range(2, 8)), 5'($urandom_range(2, 8)), 20);
    run_phase(5'd2, 5'd17, 20);
    wait_idle();

    $display("tb_top: %0d items accepted, %0d column sums checked", items_in, results_seen);
    $display("tb_top: %0d register settings, incl. zero, max and saturated counts",
             settings_run);
    if (error_count == 0 && expected_sums.size() == 0) begin
      $display("tb_top: done, clean");
    end else begin
      $display("tb_top: %0d mismatches, %0d sums never emitted", error_count,
               expected_sums.size());
      $display("tb_top: done, errors");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #5ms;
    $display("tb_top: timeout, %0d sums still expected", expected_sums.size());
    $display("tb_top: done, errors");
    $finish;
  end

endmodule

`default_nettype wire
